[sv/plg_pkg.sv]
// shared types and constants of the luma-to-glyph text renderer
package plg_pkg;

    localparam int DIM_W = 13;
    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 3;
    localparam int GLYPH_BITS = 32;
    localparam int GLYPH_MAX_BYTES = 4;
    localparam int LEN_W = 3;
    localparam int LEN_CODE_W = 2;
    localparam int LUMA_SHIFT = 8;
    localparam int SUM_W = 18;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;
    localparam int QUEUE_CW = 3;
    localparam int BYTE_IDX_W = 3;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_WEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_ROUNDING = 3'd5;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [7:0] RST_RED_WEIGHT = 8'd77;
    localparam logic [7:0] RST_GREEN_WEIGHT = 8'd150;
    localparam logic [7:0] RST_BLUE_WEIGHT = 8'd29;
    localparam logic [7:0] RST_LUMA_ROUNDING = 8'd128;

    // one rendered pixel on its way to the byte serialiser
    typedef struct packed {
        logic [GLYPH_BITS-1:0] glyph;
        logic [LEN_CODE_W-1:0] len_code;
        logic                  row_end;
        logic                  frame_last;
    } t_job;

endpackage

[sv/plg_front.sv]
// front end: input transfer, config registers, luma, glyph table and raster counters
module plg_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_entry_index,
    input  logic [plg_pkg::GLYPH_BITS-1:0] i_entry_bytes,
    input  logic [plg_pkg::LEN_W-1:0]     i_entry_length,
    input  logic                          i_cfg_we,
    input  logic [plg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_pop,
    output logic                          o_push,
    output plg_pkg::t_job                 o_job
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DWID = $clog2(MAX_DIMENSION) + 1;
    localparam int EW = (DWID > plg_pkg::DIM_W) ? DWID : plg_pkg::DIM_W;

    logic [plg_pkg::DIM_W-1:0] r_width;
    logic [plg_pkg::DIM_W-1:0] r_height;
    logic [7:0] r_wr;
    logic [7:0] r_wg;
    logic [7:0] r_wb;
    logic [7:0] r_rnd;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [plg_pkg::QUEUE_CW-1:0] r_credit, n_credit;

    logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
    logic [CW-1:0] w_last, h_last;
    logic row_end, frame_last;

    logic in_xfer, render_xfer, load_xfer;

    logic        r_s1_valid;
    logic [15:0] r_prod_r, r_prod_g, r_prod_b;
    logic        r_s1_row_end, r_s1_frame_last;
    logic [plg_pkg::SUM_W-1:0] sum;
    logic [7:0]  luma;

    logic        r_s2_valid;
    logic        r_s2_row_end, r_s2_frame_last;
    logic [plg_pkg::GLYPH_BITS+plg_pkg::LEN_CODE_W-1:0] r_rd;
    logic [plg_pkg::GLYPH_BITS+plg_pkg::LEN_CODE_W-1:0] r_glyph [256];

    logic [plg_pkg::LEN_W-1:0]      len_fix;
    logic [plg_pkg::LEN_CODE_W-1:0] len_code;

    assign o_stall = (r_credit == plg_pkg::QUEUE_CW'(plg_pkg::QUEUE_DEPTH));
    assign in_xfer = i_valid && !o_stall;
    assign render_xfer = in_xfer && (i_operation == plg_pkg::OP_RENDER);
    assign load_xfer = in_xfer && (i_operation == plg_pkg::OP_LOAD);

    // effective frame size: zero acts as one, large values saturate
    always_comb begin
        w_ext = EW'(r_width);
        h_ext = EW'(r_height);
        if (w_ext == '0) begin
            w_eff = EW'(1);
        end else if (w_ext > EW'(MAX_DIMENSION)) begin
            w_eff = EW'(MAX_DIMENSION);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = EW'(1);
        end else if (h_ext > EW'(MAX_DIMENSION)) begin
            h_eff = EW'(MAX_DIMENSION);
        end else begin
            h_eff = h_ext;
        end
        w_last = CW'(w_eff - EW'(1));
        h_last = CW'(h_eff - EW'(1));
    end

    assign row_end = (r_col >= w_last);
    assign frame_last = row_end && (r_row >= h_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (render_xfer) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_last ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    // one credit per render item between transfer and the queue pop
    always_comb begin
        n_credit = r_credit;
        case ({render_xfer, i_pop})
            2'b10:   n_credit = r_credit + plg_pkg::QUEUE_CW'(1);
            2'b01:   n_credit = r_credit - plg_pkg::QUEUE_CW'(1);
            default: n_credit = r_credit;
        endcase
    end

    always_comb begin
        len_fix = i_entry_length;
        if (len_fix == '0) begin
            len_fix = plg_pkg::LEN_W'(1);
        end
        if (len_fix > plg_pkg::LEN_W'(plg_pkg::GLYPH_MAX_BYTES)) begin
            len_fix = plg_pkg::LEN_W'(plg_pkg::GLYPH_MAX_BYTES);
        end
        len_code = plg_pkg::LEN_CODE_W'(len_fix - plg_pkg::LEN_W'(1));
    end

    // weighted sum, then clamp of the shifted luma to eight bits
    always_comb begin
        sum = plg_pkg::SUM_W'(r_prod_r) + plg_pkg::SUM_W'(r_prod_g)
            + plg_pkg::SUM_W'(r_prod_b) + plg_pkg::SUM_W'(r_rnd);
        if (sum[plg_pkg::SUM_W-1:plg_pkg::LUMA_SHIFT+8] != '0) begin
            luma = 8'hFF;
        end else begin
            luma = sum[plg_pkg::LUMA_SHIFT+7:plg_pkg::LUMA_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= plg_pkg::RST_FRAME_WIDTH;
            r_height <= plg_pkg::RST_FRAME_HEIGHT;
            r_wr <= plg_pkg::RST_RED_WEIGHT;
            r_wg <= plg_pkg::RST_GREEN_WEIGHT;
            r_wb <= plg_pkg::RST_BLUE_WEIGHT;
            r_rnd <= plg_pkg::RST_LUMA_ROUNDING;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                plg_pkg::CFG_FRAME_WIDTH:   r_width <= i_cfg_data;
                plg_pkg::CFG_FRAME_HEIGHT:  r_height <= i_cfg_data;
                plg_pkg::CFG_RED_WEIGHT:    r_wr <= i_cfg_data[7:0];
                plg_pkg::CFG_GREEN_WEIGHT:  r_wg <= i_cfg_data[7:0];
                plg_pkg::CFG_BLUE_WEIGHT:   r_wb <= i_cfg_data[7:0];
                plg_pkg::CFG_LUMA_ROUNDING: r_rnd <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_credit <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_credit <= n_credit;
            r_s1_valid <= render_xfer;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (render_xfer) begin
            r_prod_r <= r_wr * i_red;
            r_prod_g <= r_wg * i_green;
            r_prod_b <= r_wb * i_blue;
            r_s1_row_end <= row_end;
            r_s1_frame_last <= frame_last;
        end
        r_s2_row_end <= r_s1_row_end;
        r_s2_frame_last <= r_s1_frame_last;
    end

    // glyph table: loads write at transfer, renders read at the edge after transfer
    always_ff @(posedge i_clk) begin
        if (load_xfer) begin
            r_glyph[i_entry_index] <= {len_code, i_entry_bytes};
        end
        r_rd <= r_glyph[luma];
    end

    assign o_push = r_s2_valid;
    assign o_job.glyph = r_rd[plg_pkg::GLYPH_BITS-1:0];
    assign o_job.len_code = r_rd[plg_pkg::GLYPH_BITS+plg_pkg::LEN_CODE_W-1:plg_pkg::GLYPH_BITS];
    assign o_job.row_end = r_s2_row_end;
    assign o_job.frame_last = r_s2_frame_last;

endmodule

[sv/plg_queue.sv]
// short queue of rendered pixels between front and back end
module plg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  plg_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output plg_pkg::t_job o_job
);

    plg_pkg::t_job r_mem [plg_pkg::QUEUE_DEPTH];
    logic [plg_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [plg_pkg::QUEUE_CW-1:0] r_count, n_count;

    // the front end holds credits, so a push never meets a full queue
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + plg_pkg::QUEUE_CW'(1);
            2'b01:   n_count = r_count - plg_pkg::QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wp <= r_wp + plg_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + plg_pkg::QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_job = r_mem[r_rp];

endmodule

[sv/plg_back.sv]
// back end: serialises glyph bytes and row newlines into the output register
module plg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  plg_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_is_newline,
    output logic          o_last,
    output logic          o_frame_end
);

    logic [plg_pkg::BYTE_IDX_W-1:0] r_idx;
    logic r_valid;
    logic [7:0] r_byte;
    logic r_nl, r_last, r_fend;

    logic load_out, advance, done, need_nl, final_byte;
    logic [plg_pkg::BYTE_IDX_W-1:0] len3;
    logic [7:0] c_byte;
    logic c_nl, c_last, c_fend;

    assign load_out = !r_valid || !i_stall;
    assign advance = load_out && i_q_valid;
    assign len3 = plg_pkg::BYTE_IDX_W'(i_q_job.len_code);
    assign need_nl = i_q_job.row_end && !i_q_job.frame_last;
    assign final_byte = (r_idx == len3);

    always_comb begin
        if (r_idx <= len3) begin
            c_byte = i_q_job.glyph[{r_idx[1:0], 3'b000} +: 8];
            c_nl = 1'b0;
            c_last = final_byte && !need_nl;
            c_fend = final_byte && i_q_job.frame_last;
            done = final_byte && !need_nl;
        end else begin
            // row-ending newline after the glyph bytes
            c_byte = plg_pkg::NEWLINE_BYTE;
            c_nl = 1'b1;
            c_last = 1'b1;
            c_fend = 1'b0;
            done = 1'b1;
        end
    end

    assign o_pop = advance && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_valid <= 1'b0;
        end else if (load_out) begin
            r_valid <= i_q_valid;
            if (advance) begin
                r_idx <= done ? '0 : r_idx + plg_pkg::BYTE_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= c_byte;
            r_nl <= c_nl;
            r_last <= c_last;
            r_fend <= c_fend;
        end
    end

    assign o_valid = r_valid;
    assign o_out_byte = r_byte;
    assign o_is_newline = r_nl;
    assign o_last = r_last;
    assign o_frame_end = r_fend;

endmodule

[sv/pixel_luma_to_text_glyph.sv]
// top level of the RGB pixel to text glyph renderer
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_operation, i_red, i_green, i_blue,
//                                            i_entry_index, i_entry_bytes, i_entry_length
//  output    out        o_valid / i_stall    o_out_byte, o_is_newline, o_last, o_frame_end
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// one input item per cycle is taken while o_stall is low; a render item then gives one
// output byte per glyph byte plus one for a row newline, and a load item gives no result.
// the first byte of a render item goes through the product registers, the glyph table
// read, the queue and the output register.
// reset restores the register defaults and clears counters and queue; the glyph
// table keeps its contents and has no clearing pass.
// the input stalls while four render items lie between transfer and their queue pop.
module pixel_luma_to_text_glyph #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [7:0]                    i_entry_index,
    input  logic [plg_pkg::GLYPH_BITS-1:0] i_entry_bytes,
    input  logic [plg_pkg::LEN_W-1:0]     i_entry_length,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [7:0]                    o_out_byte,
    output logic                          o_is_newline,
    output logic                          o_last,
    output logic                          o_frame_end,
    input  logic                          i_cfg_we,
    input  logic [plg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plg_pkg::CFG_W-1:0]     i_cfg_data
);

    logic          push, pop, q_valid;
    plg_pkg::t_job push_job, q_job;

    plg_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_entry_index  (i_entry_index),
        .i_entry_bytes  (i_entry_bytes),
        .i_entry_length (i_entry_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pop          (pop),
        .o_push         (push),
        .o_job          (push_job)
    );

    plg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    plg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_is_newline (o_is_newline),
        .o_last       (o_last),
        .o_frame_end  (o_frame_end)
    );

endmodule

[bench/plg_text_checker.sv]
// checker for the luma-to-glyph renderer: watches both channels, predicts text bytes, compares
`timescale 1ns / 100ps
module plg_text_checker
    import plg_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_red,
    input  logic [7:0]            i_green,
    input  logic [7:0]            i_blue,
    input  logic [7:0]            i_entry_index,
    input  logic [GLYPH_BITS-1:0] i_entry_bytes,
    input  logic [LEN_W-1:0]      i_entry_length,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [7:0]            i_out_byte,
    input  logic                  i_is_newline,
    input  logic                  i_last,
    input  logic                  i_frame_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_newline;
        logic       last;
        logic       frame_end;
    } t_text_byte;

    t_text_byte expected_text[$];

    logic [GLYPH_BITS-1:0] glyph_bits [256];
    logic [LEN_CODE_W-1:0] glyph_len_code [256];
    logic [11:0]           column_pos;
    logic [11:0]           row_pos;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [7:0]            red_w;
    logic [7:0]            green_w;
    logic [7:0]            blue_w;
    logic [7:0]            rounding;
    int                    fail_count = 0;

    initial begin
        for (int k = 0; k < 256; k++) begin
            glyph_bits[k] = '0;
            glyph_len_code[k] = '0;
        end
    end

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_DIMENSION)) return DIM_W'(MAX_DIMENSION);
        return v;
    endfunction

    task automatic store_glyph(input logic [7:0] idx, input logic [GLYPH_BITS-1:0] bytes,
                               input logic [LEN_W-1:0] len_in);
        logic [LEN_W-1:0] n;
        n = len_in;
        if (n == '0) n = LEN_W'(1);
        if (n > LEN_W'(GLYPH_MAX_BYTES)) n = LEN_W'(GLYPH_MAX_BYTES);
        glyph_bits[idx] = bytes;
        glyph_len_code[idx] = LEN_CODE_W'(n - LEN_W'(1));
    endtask

    // one pixel: glyph bytes of its luma level, then a newline where a row ends inside the frame
    task automatic render_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [SUM_W-1:0]            weighted;
        logic [SUM_W-LUMA_SHIFT-1:0] luma_wide;
        logic [7:0]                  luma;
        logic [LEN_W-1:0]            n_bytes;
        logic [DIM_W-1:0]            w;
        logic [DIM_W-1:0]            h;
        logic                        row_end;
        logic                        frame_last;
        logic                        final_byte;
        t_text_byte                  t;
        weighted = SUM_W'(red_w) * SUM_W'(r) + SUM_W'(green_w) * SUM_W'(g)
                 + SUM_W'(blue_w) * SUM_W'(b) + SUM_W'(rounding);
        luma_wide = weighted[SUM_W-1:LUMA_SHIFT];
        luma = (luma_wide > 255) ? 8'hFF : luma_wide[7:0];
        n_bytes = LEN_W'(glyph_len_code[luma]) + LEN_W'(1);
        w = dim_clamp(width_reg);
        h = dim_clamp(height_reg);
        // counters at or past a shrunk limit end the row or frame here
        row_end = {1'b0, column_pos} >= w - DIM_W'(1);
        frame_last = row_end && ({1'b0, row_pos} >= h - DIM_W'(1));
        for (int k = 0; k < int'(n_bytes); k++) begin
            final_byte = (k == int'(n_bytes) - 1);
            t.out_byte = glyph_bits[luma][8*k +: 8];
            t.is_newline = 1'b0;
            t.last = final_byte && !(row_end && !frame_last);
            t.frame_end = final_byte && frame_last;
            expected_text.push_back(t);
        end
        if (row_end && !frame_last) begin
            t.out_byte = NEWLINE_BYTE;
            t.is_newline = 1'b1;
            t.last = 1'b1;
            t.frame_end = 1'b0;
            expected_text.push_back(t);
        end
        if (row_end) begin
            column_pos = '0;
            row_pos = frame_last ? 12'd0 : row_pos + 12'd1;
        end else begin
            column_pos = column_pos + 12'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_text_byte want;
        if (!i_rst_n) begin
            column_pos = '0;
            row_pos = '0;
            width_reg = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            red_w = RST_RED_WEIGHT;
            green_w = RST_GREEN_WEIGHT;
            blue_w = RST_BLUE_WEIGHT;
            rounding = RST_LUMA_ROUNDING;
            expected_text.delete();
        end else begin
            // a pixel's results never leave in its own transfer cycle, so check before predicting
            if (i_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    $error("out_byte: nothing expected, got %h", i_out_byte);
                    fail_count++;
                end else begin
                    want = expected_text.pop_front();
                    check_field("out_byte", want.out_byte, i_out_byte);
                    check_field("is_newline", 8'(want.is_newline), 8'(i_is_newline));
                    check_field("last", 8'(want.last), 8'(i_last));
                    check_field("frame_end", 8'(want.frame_end), 8'(i_frame_end));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   width_reg = i_cfg_data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT:  height_reg = i_cfg_data[DIM_W-1:0];
                    CFG_RED_WEIGHT:    red_w = i_cfg_data[7:0];
                    CFG_GREEN_WEIGHT:  green_w = i_cfg_data[7:0];
                    CFG_BLUE_WEIGHT:   blue_w = i_cfg_data[7:0];
                    CFG_LUMA_ROUNDING: rounding = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_LOAD) begin
                    store_glyph(i_entry_index, i_entry_bytes, i_entry_length);
                end else begin
                    render_pixel(i_red, i_green, i_blue);
                end
            end
        end
        o_pending <= expected_text.size();
        o_errors <= fail_count;
    end

endmodule

[bench/tb_pixel_luma_to_text_glyph.sv]
// testbench top for the luma-to-glyph renderer: stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module tb_pixel_luma_to_text_glyph;
    import plg_pkg::*;

    localparam int MAX_DIMENSION = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 210;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  i_operation = OP_LOAD;
    logic [7:0]            i_red = '0;
    logic [7:0]            i_green = '0;
    logic [7:0]            i_blue = '0;
    logic [7:0]            i_entry_index = '0;
    logic [GLYPH_BITS-1:0] i_entry_bytes = '0;
    logic [LEN_W-1:0]      i_entry_length = '0;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_out_byte;
    logic                  o_is_newline;
    logic                  o_last;
    logic                  o_frame_end;

    int text_pending;
    int check_errors;
    int cycle_count = 0;
    int items_sent = 0;
    bit send_calm = 1'b0;
    bit take_calm = 1'b0;
    bit glyph_loaded [256];
    logic [7:0] cur_rw = RST_RED_WEIGHT;
    logic [7:0] cur_gw = RST_GREEN_WEIGHT;
    logic [7:0] cur_bw = RST_BLUE_WEIGHT;
    logic [7:0] cur_rnd = RST_LUMA_ROUNDING;

    pixel_luma_to_text_glyph #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .i_entry_index(i_entry_index),
        .i_entry_bytes(i_entry_bytes),
        .i_entry_length(i_entry_length),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_byte(o_out_byte),
        .o_is_newline(o_is_newline),
        .o_last(o_last),
        .o_frame_end(o_frame_end),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    plg_text_checker #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_valid),
        .i_in_stall(o_stall),
        .i_operation(i_operation),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .i_entry_index(i_entry_index),
        .i_entry_bytes(i_entry_bytes),
        .i_entry_length(i_entry_length),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_out_byte(o_out_byte),
        .i_is_newline(o_is_newline),
        .i_last(o_last),
        .i_frame_end(o_frame_end),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_pending(text_pending),
        .o_errors(check_errors)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_pixel_luma_to_text_glyph: done, errors");
            $finish;
        end
    end

    // output side: after each transfer hold off for a drawn number of cycles
    initial begin : take_side
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                if (hold == 0) i_stall <= 1'b0;
            end else if (o_valid === 1'b1 && !i_stall) begin
                if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
                hold = take_calm ? 0 : $urandom_range(0, 8);
                if (hold > 0) i_stall <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] idx,
                             input logic [GLYPH_BITS-1:0] bytes, input logic [LEN_W-1:0] len);
        int gap;
        if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        items_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        i_entry_index <= idx;
        i_entry_bytes <= bytes;
        i_entry_length <= len;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    // luma level a pixel reads under the weights last written
    function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(cur_rw) * SUM_W'(r) + SUM_W'(cur_gw) * SUM_W'(g)
          + SUM_W'(cur_bw) * SUM_W'(b) + SUM_W'(cur_rnd);
        return (s[SUM_W-1:LUMA_SHIFT+8] != '0) ? 8'hFF : s[LUMA_SHIFT+7:LUMA_SHIFT];
    endfunction

    task automatic load_glyph(input logic [7:0] idx, input logic [GLYPH_BITS-1:0] bytes,
                              input logic [LEN_W-1:0] len);
        glyph_loaded[idx] = 1'b1;
        send_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), idx, bytes, len);
    endtask

    // fields a render ignores are still randomised; a level with no glyph yet gets one first
    task automatic render(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        logic [7:0] level;
        level = luma_of(r, g, b);
        if (!glyph_loaded[level]) begin
            load_glyph(level, $urandom, LEN_W'($urandom));
        end
        send_item(OP_RENDER, r, g, b, 8'($urandom), $urandom, LEN_W'($urandom));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (text_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // weights carry random upper bits, which the block drops
    task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [7:0] rw, input logic [7:0] gw,
                              input logic [7:0] bw, input logic [7:0] rnd);
        cur_rw = rw;
        cur_gw = gw;
        cur_bw = bw;
        cur_rnd = rnd;
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        cfg_write(CFG_RED_WEIGHT, {(CFG_W-8)'($urandom), rw});
        cfg_write(CFG_GREEN_WEIGHT, {(CFG_W-8)'($urandom), gw});
        cfg_write(CFG_BLUE_WEIGHT, {(CFG_W-8)'($urandom), bw});
        cfg_write(CFG_LUMA_ROUNDING, {(CFG_W-8)'($urandom), rnd});
        for (int k = int'(CFG_LUMA_ROUNDING) + 1; k < (1 << CFG_IDX_W); k++) begin
            cfg_write(CFG_IDX_W'(k), CFG_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dimension();
        case ($urandom_range(0, 9))
            0: return DIM_W'(0);
            1: return DIM_W'($urandom_range(MAX_DIMENSION, (1 << DIM_W) - 1));
            default: return DIM_W'($urandom_range(1, 6));
        endcase
    endfunction

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset weights: black reads entry 0, white entry 255; loads straight before use
        load_glyph(8'h00, $urandom, LEN_W'(0));
        render(8'h00, 8'h00, 8'h00);
        load_glyph(8'hFF, $urandom, '1);
        render(8'hFF, 8'hFF, 8'hFF);
        load_glyph(8'h00, 32'hFFFF_FFFF, LEN_W'(GLYPH_MAX_BYTES));
        render(8'h00, 8'h00, 8'h00);
        load_glyph(8'h00, 32'h0000_0000, LEN_W'(GLYPH_MAX_BYTES + 1));
        render(8'h00, 8'h00, 8'h00);
        settle();

        // one-pixel frames at full weight, white overflows the luma range
        set_config(DIM_W'(1), DIM_W'(1), 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        render(8'hFF, 8'hFF, 8'hFF);
        render(8'h00, 8'h00, 8'h00);
        render(8'h80, 8'h7F, 8'h01);
        settle();

        // zero dimensions act as one, zero weights pin the luma to zero
        set_config(DIM_W'(0), DIM_W'(0), 8'h00, 8'h00, 8'h00, 8'h00);
        render(8'hFF, 8'hFF, 8'hFF);
        render(pick_level(), pick_level(), pick_level());
        settle();

        // oversized dimensions act as the maximum
        set_config('1, '1, RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
                   RST_LUMA_ROUNDING);
        render(pick_level(), pick_level(), pick_level());
        render(pick_level(), pick_level(), pick_level());
        settle();

        // three by two frame, then shrink both dimensions part way through the second row
        set_config(DIM_W'(3), DIM_W'(2), RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
                   RST_LUMA_ROUNDING);
        repeat (4) render(pick_level(), pick_level(), pick_level());
        settle();
        set_config(DIM_W'(1), DIM_W'(1), RST_RED_WEIGHT, RST_GREEN_WEIGHT, RST_BLUE_WEIGHT,
                   RST_LUMA_ROUNDING);
        repeat (2) render(pick_level(), pick_level(), pick_level());
        settle();

        // random phases; frame position carries over each change of geometry
        for (int p = 0; p < 8; p++) begin
            set_config(pick_dimension(), pick_dimension(), pick_weight(), pick_weight(),
                       pick_weight(), pick_weight());
            for (int k = 0; k < 24 && items_sent < ITEM_TARGET; k++) begin
                if ($urandom_range(0, 6) == 0) begin
                    load_glyph(8'($urandom), $urandom, LEN_W'($urandom));
                end else begin
                    render(pick_level(), pick_level(), pick_level());
                end
            end
            settle();
        end

        if (check_errors == 0) begin
            $display("tb_pixel_luma_to_text_glyph: done, clean");
        end else begin
            $display("tb_pixel_luma_to_text_glyph: done, errors");
        end
        $finish;
    end

endmodule
